FILE: sv/xor_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// XOR frame deframer assertion macros
// Shared assertion shorthands for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef XOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define XOR_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define XFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/xfd_pkg.sv
// ----------------------------------------------------------------------------
// XOR frame deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package xfd_pkg;

  localparam int unsigned MinLength = 6;
  localparam int unsigned AddrBytes = 4;

  localparam logic [7:0]  HeaderReset     = 8'h29;
  localparam logic [7:0]  TerminatorReset = 8'h0d;
  localparam logic [15:0] MaxLengthReset  = 16'd251;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LENHI = 3'd3,
    PH_LENLO = 3'd4,
    PH_BODY  = 3'd5,
    PH_CSUM  = 3'd6,
    PH_TERM  = 3'd7
  } xfd_phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_BAD_TERM  = 2'd2,
    ST_BAD_CSUM  = 2'd3
  } xfd_status_t;

  typedef enum logic [1:0] {
    CFG_HEADER     = 2'd0,
    CFG_TERMINATOR = 2'd1,
    CFG_MAX_LENGTH = 2'd2
  } xfd_cfg_idx_t;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0]  header;
    logic [7:0]  terminator;
    logic [15:0] max_length;
  } xfd_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic        address_part;
    logic [7:0]  command_code;
    logic [1:0]  frame_status;
  } xfd_result_t;

endpackage

FILE: sv/xfd_parser.sv
// ----------------------------------------------------------------------------
// XOR frame deframer parser
// Per-byte frame state machine: header hunt, command, length, body,
// checksum and terminator, with a running XOR.
// ----------------------------------------------------------------------------
module xfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [7:0]        rx_byte,
  input  xfd_pkg::xfd_cfg_t cfg,
  output logic              res_valid,
  output xfd_pkg::xfd_result_t res
);
  import xfd_pkg::*;

  xfd_phase_t  phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;

  logic [15:0] len_full;
  logic        len_bad;
  logic [15:0] cnt_inc;
  logic        body_last;
  logic [7:0]  xor_step;

  assign len_full  = {len_r[15:8], rx_byte};
  assign len_bad   = (len_full < 16'(MinLength)) || (len_full > cfg.max_length);
  assign cnt_inc   = cnt_r + 16'd1;
  assign body_last = cnt_inc >= (len_r - 16'd2);
  assign xor_step  = xor_r ^ rx_byte;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_en) begin
      case (phase_r)
        PH_HUNT1: if (rx_byte == cfg.header) phase_nxt = PH_HUNT2;
        PH_HUNT2: phase_nxt = (rx_byte == cfg.header) ? PH_CMD : PH_HUNT1;
        PH_CMD:   phase_nxt = PH_LENHI;
        PH_LENHI: phase_nxt = PH_LENLO;
        PH_LENLO: phase_nxt = len_bad ? PH_HUNT1 : PH_BODY;
        PH_BODY:  if (body_last) phase_nxt = PH_CSUM;
        PH_CSUM:  phase_nxt = PH_TERM;
        PH_TERM:  phase_nxt = PH_HUNT1;
        default:  phase_nxt = PH_HUNT1;
      endcase
    end
  end

  // frame fields
  always_comb begin
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    xor_nxt = xor_r;
    if (byte_en) begin
      case (phase_r)
        PH_HUNT1: if (rx_byte == cfg.header) xor_nxt = rx_byte;
        PH_HUNT2: if (rx_byte == cfg.header) xor_nxt = xor_step;
        PH_CMD: begin
          cmd_nxt = rx_byte;
          xor_nxt = xor_step;
        end
        PH_LENHI: begin
          len_nxt = {rx_byte, 8'h00};
          xor_nxt = xor_step;
        end
        PH_LENLO: begin
          len_nxt = len_full;
          xor_nxt = xor_step;
          if (!len_bad) cnt_nxt = '0;
        end
        PH_BODY: begin
          cnt_nxt = cnt_inc;
          xor_nxt = xor_step;
        end
        PH_CSUM:  xor_nxt = xor_step;
        default:  xor_nxt = xor_r;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = KIND_BODY;
    res.body_byte      = '0;
    res.address_part   = 1'b0;
    res.command_code   = cmd_r;
    res.frame_status   = ST_OK;
    case (phase_r)
      PH_LENLO: begin
        res_valid        = byte_en && len_bad;
        res.kind         = KIND_VERDICT;
        res.frame_status = ST_BAD_LEN;
      end
      PH_BODY: begin
        res_valid        = byte_en;
        res.body_byte    = rx_byte;
        res.address_part = cnt_r < 16'(AddrBytes);
      end
      PH_TERM: begin
        res_valid = byte_en;
        res.kind  = KIND_VERDICT;
        if (rx_byte != cfg.terminator) begin
          res.frame_status = ST_BAD_TERM;
        end else if (xor_r != 8'h00) begin
          res.frame_status = ST_BAD_CSUM;
        end else begin
          res.frame_status = ST_OK;
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

FILE: sv/xor_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// XOR frame deframer core
// Byte-serial parser for length-prefixed frames with an XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per request. Result channel (out_valid / out_stall / out_*) gives body
//   bytes (out_kind 0) and end-of-frame verdicts (out_kind 1). Bytes outside
//   a frame, header, command and checksum bytes and an in-range length give no result.
//   A byte's result is registered in the output register as the byte is
//   accepted.
//   Throughput: one byte per cycle while in_stall is low; the per-byte compare,
//   counter and XOR sit between the state registers and the single output register.
//   Stall: while a held result is stalled, in_stall is raised; as soon as the
//   result is taken a new byte is accepted in the same cycle.
//   Reset (rst_n low, synchronous): parser returns to header hunt, output is
//   emptied and the registers return to header 0x29, terminator 0x0d and
//   max length 251. Configuration via cfg_we / cfg_index / cfg_wdata is to be
//   written by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "xor_frame_deframer_core_defines.svh"

module xor_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_body_byte,
  output logic        out_address_part,
  output logic [7:0]  out_command_code,
  output logic [1:0]  out_frame_status
);
  import xfd_pkg::*;

  xfd_cfg_t    cfg_r;
  logic        out_valid_r;
  xfd_result_t out_r;
  logic        in_take;
  logic        res_valid;
  xfd_result_t res;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header     <= HeaderReset;
      cfg_r.terminator <= TerminatorReset;
      cfg_r.max_length <= MaxLengthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER:     cfg_r.header     <= cfg_wdata[7:0];
        CFG_TERMINATOR: cfg_r.terminator <= cfg_wdata[7:0];
        CFG_MAX_LENGTH: cfg_r.max_length <= cfg_wdata;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  xfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_take),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_body_byte    = out_r.body_byte;
  assign out_address_part = out_r.address_part;
  assign out_command_code = out_r.command_code;
  assign out_frame_status = out_r.frame_status;

  `XFD_ASSERT_IMP(a_stall_only_full, in_stall, out_valid_r, "stall without held result")
  `XFD_ASSERT_IMP(a_verdict_clean, out_valid_r && out_r.kind == KIND_VERDICT,
                  out_r.body_byte == 8'h00 && !out_r.address_part,
                  "verdict carries body data")
  `XFD_ASSERT_IMP(a_body_ok, out_valid_r && out_r.kind == KIND_BODY,
                  out_r.frame_status == ST_OK, "body result with error status")
  `XFD_ASSERT_NXT(a_load_valid, in_take && res_valid, out_valid_r, "result lost on load")

endmodule

FILE: verif/tb_xor_frame_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XOR frame deframer core testbench
// Sends directed and random byte streams (whole frames, short and long
// lengths, checksum and terminator faults, truncated frames, line noise)
// under five register settings. Both channels idle at random in some settings. A frame
// predictor in the scoreboard checks every body byte and verdict in order.
// ----------------------------------------------------------------------------
module tb_xor_frame_deframer_core;
  import xfd_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 250;

  class frame_checker;
    xfd_cfg_t    cfg;
    xfd_phase_t  phase;
    logic [7:0]  cmd;
    logic [15:0] flen;
    logic [15:0] nbody;
    logic [7:0]  xacc;
    xfd_result_t exp_q[$];
    int          n_err;
    int          n_body;
    int          n_verdict;
    int          n_status[4];

    function new();
      cfg.header     = HeaderReset;
      cfg.terminator = TerminatorReset;
      cfg.max_length = MaxLengthReset;
      phase = PH_HUNT1;
      cmd   = '0;
      flen  = '0;
      nbody = '0;
      xacc  = '0;
    endfunction

    function void set_reg(xfd_cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_HEADER:     cfg.header     = val[7:0];
        CFG_TERMINATOR: cfg.terminator = val[7:0];
        CFG_MAX_LENGTH: cfg.max_length = val;
        default: ;
      endcase
    endfunction

    function void push_verdict(xfd_status_t st);
      xfd_result_t r;
      r = '0;
      r.kind         = KIND_VERDICT;
      r.command_code = cmd;
      r.frame_status = st;
      exp_q.push_back(r);
    endfunction

    // Advance the parser by one accepted request and queue what it yields.
    function void note_byte(logic [7:0] b);
      xfd_result_t r;
      r = '0;
      case (phase)
        PH_HUNT1: if (b == cfg.header) begin
          xacc  = b;
          phase = PH_HUNT2;
        end
        PH_HUNT2: if (b == cfg.header) begin
          xacc  = xacc ^ b;
          phase = PH_CMD;
        end else begin
          phase = PH_HUNT1;
        end
        PH_CMD: begin
          cmd   = b;
          xacc  = xacc ^ b;
          phase = PH_LENHI;
        end
        PH_LENHI: begin
          flen  = {b, 8'h00};
          xacc  = xacc ^ b;
          phase = PH_LENLO;
        end
        PH_LENLO: begin
          flen  = {flen[15:8], b};
          xacc  = xacc ^ b;
          if (flen < MinLength || flen > cfg.max_length) begin
            phase = PH_HUNT1;
            push_verdict(ST_BAD_LEN);
          end else begin
            nbody = '0;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          xacc           = xacc ^ b;
          r.kind         = KIND_BODY;
          r.body_byte    = b;
          r.address_part = (nbody < AddrBytes);
          r.command_code = cmd;
          nbody          = nbody + 16'd1;
          if (int'(nbody) >= int'(flen) - 2) phase = PH_CSUM;
          exp_q.push_back(r);
        end
        PH_CSUM: begin
          xacc  = xacc ^ b;
          phase = PH_TERM;
        end
        default: begin
          phase = PH_HUNT1;
          if (b != cfg.terminator) push_verdict(ST_BAD_TERM);
          else if (xacc != 8'h00) push_verdict(ST_BAD_CSUM);
          else push_verdict(ST_OK);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      if (n_err < 40) $display("[%0t] mismatch: %s", $time, msg);
      n_err++;
    endtask

    task check_result(xfd_result_t got);
      xfd_result_t want;
      if (exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0b byte=%02h status=%0d",
                                  got.kind, got.body_byte, got.frame_status));
        return;
      end
      want = exp_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.body_byte !== want.body_byte)
        report_mismatch($sformatf("body_byte %02h, want %02h", got.body_byte,
                                  want.body_byte));
      if (got.address_part !== want.address_part)
        report_mismatch($sformatf("address_part %0b, want %0b", got.address_part,
                                  want.address_part));
      if (got.command_code !== want.command_code)
        report_mismatch($sformatf("command_code %02h, want %02h", got.command_code,
                                  want.command_code));
      if (got.frame_status !== want.frame_status)
        report_mismatch($sformatf("frame_status %0d, want %0d", got.frame_status,
                                  want.frame_status));
      if (want.kind == KIND_VERDICT) begin
        n_verdict++;
        n_status[want.frame_status]++;
      end else begin
        n_body++;
      end
    endtask

    task check_drained();
      if (exp_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", exp_q.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_HEADER;
  logic [15:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        out_kind;
  logic [7:0]  out_body_byte;
  logic        out_address_part;
  logic [7:0]  out_command_code;
  logic [1:0]  out_frame_status;

  frame_checker sb = new();
  int n_sent      = 0;
  int quiet       = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit hold_req    = 1'b0;

  xor_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_body_byte    (out_body_byte),
    .out_address_part (out_address_part),
    .out_command_code (out_command_code),
    .out_frame_status (out_frame_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : result_monitor
    xfd_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind         = out_kind;
      got.body_byte    = out_body_byte;
      got.address_part = out_address_part;
      got.command_code = out_command_code;
      got.frame_status = out_frame_status;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("[%0t] timeout: no request moved for %0d cycles", $time, QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result-side back-pressure; a hold request forces one long stall.
  initial begin : rx_stall_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        out_stall  = 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input xfd_cfg_idx_t idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // cut > 0 sends only the first cut bytes of the frame.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit bad_csum, input bit bad_term, input int cut);
    logic [7:0] fb[$];
    logic [7:0] acc;
    logic [7:0] hdr;
    int         i;
    int         n;
    hdr = sb.cfg.header;
    fb  = '{hdr, hdr, cmd, len[15:8], len[7:0]};
    if (len >= MinLength && len <= sb.cfg.max_length) begin
      for (i = 0; i < int'(len) - 2; i++) fb.push_back(8'($urandom));
      acc = '0;
      foreach (fb[j]) acc = acc ^ fb[j];
      fb.push_back(bad_csum ? acc ^ (8'h01 << $urandom_range(0, 7)) : acc);
      fb.push_back(bad_term ? sb.cfg.terminator ^ 8'($urandom_range(1, 255))
                            : sb.cfg.terminator);
    end
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (i = 0; i < n; i++) send_byte(fb[i]);
  endtask

  function automatic logic [7:0] non_header();
    logic [7:0] f;
    f = 8'($urandom);
    if (f == sb.cfg.header) f = ~f;
    return f;
  endfunction

  // Feed filler until the parser is back to hunting; keep stray lengths short.
  task automatic resync();
    while (sb.phase != PH_HUNT1) begin
      if (sb.phase == PH_LENHI) send_byte(8'h00);
      else send_byte(non_header());
    end
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned mx;
    int r;
    mx = sb.cfg.max_length;
    r  = $urandom_range(0, 99);
    if (r < 6) return 16'($urandom_range(0, MinLength - 1));
    if (r < 12 && mx < 65535) return 16'($urandom_range(mx + 1, 65535));
    if (mx < MinLength) return 16'($urandom_range(0, 65535));
    if (r < 16) return 16'($urandom_range(MinLength, (mx < 300) ? mx : 300));
    return 16'($urandom_range(MinLength, (mx < 30) ? mx : 30));
  endfunction

  task automatic run_traffic(input int n_bytes, input bit shuffle_idle);
    int          stop_at;
    int          r;
    int          k;
    int          i;
    logic [15:0] len;
    stop_at = n_sent + n_bytes;
    while (n_sent < stop_at) begin
      if (shuffle_idle && $urandom_range(0, 99) < 4) begin
        tx_idle_en = $urandom_range(0, 1);
        rx_idle_en = $urandom_range(0, 1);
      end
      r = $urandom_range(0, 99);
      if (r < 72) begin
        k = $urandom_range(0, 9);
        send_frame(8'($urandom), pick_length(), k == 7 || k == 9, k >= 8, 0);
      end else if (r < 84) begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) send_byte(non_header());
      end else if (r < 94) begin
        if (sb.cfg.max_length >= MinLength)
          len = 16'($urandom_range(MinLength, (sb.cfg.max_length < 20) ?
                                               sb.cfg.max_length : 20));
        else
          len = 16'($urandom_range(MinLength, 20));
        send_frame(8'($urandom), len, 1'b0, 1'b0, $urandom_range(3, len + 4));
      end else begin
        send_byte(sb.cfg.header);
        send_byte(non_header());
      end
      resync();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: noise, minimum frame, broken header pair, both length faults,
    // terminator and checksum wrong together
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'hFF, 16'd6, 1'b0, 1'b0, 0);
    send_byte(sb.cfg.header);
    send_byte(8'h00);
    send_frame(8'h00, 16'd5, 1'b0, 1'b0, 0);
    send_frame(8'hA5, 16'hFFFF, 1'b0, 1'b0, 0);
    send_frame(8'h3C, 16'd6, 1'b1, 1'b1, 0);

    run_traffic(450, 1'b0);
    settle();

    write_reg(CFG_HEADER, 16'hFF00);
    write_reg(CFG_TERMINATOR, 16'h00FF);
    write_reg(CFG_MAX_LENGTH, 16'd6);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(350, 1'b0);
    settle();

    write_reg(CFG_HEADER, 16'h5AFF);
    write_reg(CFG_TERMINATOR, 16'hFF00);
    write_reg(CFG_MAX_LENGTH, 16'hFFFF);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b1;
    send_frame(8'h81, 16'd60, 1'b0, 1'b0, 0);
    run_traffic(500, 1'b0);
    settle();

    write_reg(CFG_HEADER, 16'($urandom));
    write_reg(CFG_TERMINATOR, 16'($urandom));
    write_reg(CFG_MAX_LENGTH, 16'($urandom_range(0, MinLength - 1)));
    rx_idle_en = 1'b0;
    run_traffic(150, 1'b0);
    settle();

    write_reg(CFG_HEADER, 16'($urandom));
    write_reg(CFG_TERMINATOR, 16'($urandom));
    write_reg(CFG_MAX_LENGTH, 16'($urandom_range(MinLength, 400)));
    run_traffic(500, 1'b1);
    settle();
    repeat (5) @(negedge clk);
    sb.check_drained();

    $display("Sent %0d bytes under five register settings; checked %0d body bytes, %0d verdicts.",
             n_sent, sb.n_body, sb.n_verdict);
    $display("Verdicts: ok %0d, bad length %0d, bad terminator %0d, bad checksum %0d.",
             sb.n_status[ST_OK], sb.n_status[ST_BAD_LEN], sb.n_status[ST_BAD_TERM],
             sb.n_status[ST_BAD_CSUM]);
    if (sb.n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/xfd_pkg.sv
sv/xfd_parser.sv
sv/xor_frame_deframer_core.sv
verif/tb_xor_frame_deframer_core.sv
